### design/rkxc_pkg.sv
// ----------------------------------------------------------------------------
// rkxc_pkg
// Shared constants, codes and controller/datapath interface types for the
// repeating-key XOR cipher with block padding.
// ----------------------------------------------------------------------------
package rkxc_pkg;

   localparam int KEY_BYTES   = 32;
   localparam int KEY_WORDS   = 4;
   localparam int WORD_W      = 64;
   localparam int KEY_POS_W   = $clog2(KEY_BYTES);
   localparam int KEY_LEN_W   = 6;
   localparam int BLOCK_BYTES = 16;
   localparam int HOLD_AW     = $clog2(BLOCK_BYTES);
   localparam int HOLD_CW     = $clog2(BLOCK_BYTES + 1);
   localparam int COUNT_W     = 5;
   localparam int COUNT_SAT   = 31;
   localparam int CSR_IW      = 3;

   typedef enum logic [CSR_IW-1:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_KEY_LENGTH  = 3'd4,
      CSR_PADDING_EN  = 3'd5,
      CSR_DIRECTION   = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWAP,
      ST_CHK_RD,
      ST_CHK,
      ST_REL,
      ST_PAD
   } state_type;

   typedef enum logic [1:0] {
      OS_XOR,
      OS_HELD,
      OS_MARKER,
      OS_ERROR
   } out_sel_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_TAIL,
      RD_REL
   } rd_sel_type;

   typedef enum logic {
      XS_INPUT,
      XS_PAD
   } xor_src_type;

   typedef struct packed {
      logic        msg_adv;
      logic        key_adv;
      xor_src_type xor_src;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
      logic        hold_append;
      logic        swap_latch;
      logic        swap_write;
      logic        pad_latch;
      logic        pad_dec;
      logic        keep_latch;
      logic        rel_adv;
      rd_sel_type  rd_sel;
      logic        finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pad_en;
      logic dir;
      logic hold_full;
      logic pad_bad;
      logic keep_zero;
      logic pad_last;
      logic rel_last;
   } dp_status_type;

endpackage

### design/rkxc_ram.sv
// ----------------------------------------------------------------------------
// rkxc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rkxc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rkxc_dp.sv
// ----------------------------------------------------------------------------
// rkxc_dp
// Datapath: config registers, key XOR, message counters, hold RAM for pad
// removal, pad check and the result output register.
// ----------------------------------------------------------------------------
module rkxc_dp
   import rkxc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [WORD_W-1:0]   csr_wdata,
   input  logic [7:0]          req_data_byte,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_result_byte,
   output logic                rsp_result_present,
   output logic                rsp_result_last,
   output logic                rsp_pad_error
);

   // configuration
   logic [WORD_W-1:0]    key_ff [KEY_WORDS];
   logic [KEY_LEN_W-1:0] key_len_ff;
   logic                 pad_en_ff;
   logic                 dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) key_ff[i] <= '0;
         key_len_ff <= KEY_LEN_W'(1);
         pad_en_ff  <= 1'b1;
         dir_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_ff[0]  <= csr_wdata;
            CSR_KEY_WORD_1: key_ff[1]  <= csr_wdata;
            CSR_KEY_WORD_2: key_ff[2]  <= csr_wdata;
            CSR_KEY_WORD_3: key_ff[3]  <= csr_wdata;
            CSR_KEY_LENGTH: key_len_ff <= csr_wdata[KEY_LEN_W-1:0];
            CSR_PADDING_EN: pad_en_ff  <= csr_wdata[0];
            CSR_DIRECTION:  dir_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // key stream
   logic [KEY_BYTES*8-1:0] key_all;
   logic [KEY_LEN_W-1:0]   len_eff;
   logic [KEY_POS_W-1:0]   key_pos_ff, key_pos_in, kp_eff;
   logic [KEY_POS_W:0]     kp_inc;
   logic [7:0]             key_byte, xor_in, xor_byte;

   assign key_all = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};

   always_comb begin
      if (key_len_ff == '0) begin
         len_eff = KEY_LEN_W'(1);
      end else if (key_len_ff > KEY_LEN_W'(KEY_BYTES)) begin
         len_eff = KEY_LEN_W'(KEY_BYTES);
      end else begin
         len_eff = key_len_ff;
      end
   end

   // a position left beyond a shrunk key length restarts at zero
   assign kp_eff   = ({1'b0, key_pos_ff} < len_eff) ? key_pos_ff : '0;
   assign kp_inc   = {1'b0, kp_eff} + (KEY_POS_W+1)'(1);
   assign key_byte = key_all[{kp_eff, 3'b000} +: 8];

   // message counters
   logic [HOLD_AW-1:0] bp_ff, bp_in, bp_next;
   logic [COUNT_W-1:0] msg_cnt_ff, msg_cnt_in;
   logic [HOLD_AW-1:0] head_ff, head_in;
   logic [HOLD_CW-1:0] hcount_ff, hcount_in;
   logic [HOLD_AW-1:0] rel_idx_ff, rel_idx_in;
   logic [HOLD_CW-1:0] pad_val_ff, pad_val_in;
   logic [HOLD_CW-1:0] pad_left_ff, pad_left_in;
   logic [HOLD_CW-1:0] keep_ff, keep_in, keep_w;
   logic [7:0]         swap_byte_ff, swap_byte_in;
   logic [HOLD_AW-1:0] pad_base;

   assign xor_in   = (cmd.xor_src == XS_PAD) ? 8'(pad_val_ff) : req_data_byte;
   assign xor_byte = xor_in ^ key_byte;
   assign bp_next  = bp_ff + HOLD_AW'(1);
   assign pad_base = cmd.msg_adv ? bp_next : bp_ff;

   // hold RAM
   logic               ram_we;
   logic [HOLD_AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]         ram_wdata, ram_rdata;

   assign ram_we    = cmd.hold_append | cmd.swap_write;
   assign ram_waddr = cmd.hold_append ? (head_ff + hcount_ff[HOLD_AW-1:0]) : head_ff;
   assign ram_wdata = cmd.hold_append ? xor_byte : swap_byte_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_TAIL: ram_raddr = head_ff + hcount_ff[HOLD_AW-1:0] - HOLD_AW'(1);
         RD_REL:  ram_raddr = head_ff + rel_idx_ff + HOLD_AW'(cmd.rel_adv);
         default: ram_raddr = head_ff;
      endcase
   end

   rkxc_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_BYTES)
   ) u_hold (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      key_pos_in   = key_pos_ff;
      bp_in        = bp_ff;
      msg_cnt_in   = msg_cnt_ff;
      head_in      = head_ff;
      hcount_in    = hcount_ff;
      rel_idx_in   = rel_idx_ff;
      pad_val_in   = pad_val_ff;
      pad_left_in  = pad_left_ff;
      keep_in      = keep_ff;
      swap_byte_in = swap_byte_ff;
      if (cmd.key_adv) begin
         key_pos_in = (kp_inc >= (KEY_POS_W+1)'(len_eff)) ? '0 : kp_inc[KEY_POS_W-1:0];
      end
      if (cmd.msg_adv) begin
         bp_in = bp_next;
         if (msg_cnt_ff < COUNT_W'(COUNT_SAT)) msg_cnt_in = msg_cnt_ff + COUNT_W'(1);
      end
      if (cmd.hold_append) hcount_in = hcount_ff + HOLD_CW'(1);
      if (cmd.swap_latch)  swap_byte_in = xor_byte;
      if (cmd.swap_write)  head_in = head_ff + HOLD_AW'(1);
      if (cmd.pad_latch) begin
         pad_val_in  = HOLD_CW'(BLOCK_BYTES) - HOLD_CW'(pad_base);
         pad_left_in = HOLD_CW'(BLOCK_BYTES) - HOLD_CW'(pad_base);
      end
      if (cmd.pad_dec)    pad_left_in = pad_left_ff - HOLD_CW'(1);
      if (cmd.keep_latch) keep_in = keep_w;
      if (cmd.rel_adv)    rel_idx_in = rel_idx_ff + HOLD_AW'(1);
      if (cmd.finish) begin
         key_pos_in = '0;
         bp_in      = '0;
         msg_cnt_in = '0;
         head_in    = '0;
         hcount_in  = '0;
         rel_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
         bp_ff      <= '0;
         msg_cnt_ff <= '0;
         head_ff    <= '0;
         hcount_ff  <= '0;
         rel_idx_ff <= '0;
      end else begin
         key_pos_ff <= key_pos_in;
         bp_ff      <= bp_in;
         msg_cnt_ff <= msg_cnt_in;
         head_ff    <= head_in;
         hcount_ff  <= hcount_in;
         rel_idx_ff <= rel_idx_in;
      end
      pad_val_ff   <= pad_val_in;
      pad_left_ff  <= pad_left_in;
      keep_ff      <= keep_in;
      swap_byte_ff <= swap_byte_in;
   end

   // pad check: read data holds the final decrypted byte here
   logic pad_bad;

   assign pad_bad = (hcount_ff == '0) || (ram_rdata == 8'd0)
                 || (ram_rdata > 8'(BLOCK_BYTES))
                 || (ram_rdata > 8'(msg_cnt_ff))
                 || (ram_rdata > 8'(hcount_ff));
   assign keep_w  = hcount_ff - ram_rdata[HOLD_CW-1:0];

   // output register
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_present_ff, out_last_ff, out_err_ff;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_last_ff <= cmd.out_last;
         unique case (cmd.out_sel)
            OS_XOR: begin
               out_byte_ff    <= xor_byte;
               out_present_ff <= 1'b1;
               out_err_ff     <= 1'b0;
            end
            OS_HELD: begin
               out_byte_ff    <= ram_rdata;
               out_present_ff <= 1'b1;
               out_err_ff     <= 1'b0;
            end
            OS_ERROR: begin
               out_byte_ff    <= 8'd0;
               out_present_ff <= 1'b0;
               out_err_ff     <= 1'b1;
            end
            default: begin
               out_byte_ff    <= 8'd0;
               out_present_ff <= 1'b0;
               out_err_ff     <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_byte    = out_byte_ff;
   assign rsp_result_present = out_present_ff;
   assign rsp_result_last    = out_last_ff;
   assign rsp_pad_error      = out_err_ff;

   assign status.out_free  = out_free;
   assign status.pad_en    = pad_en_ff;
   assign status.dir       = dir_ff;
   assign status.hold_full = (hcount_ff == HOLD_CW'(BLOCK_BYTES));
   assign status.pad_bad   = pad_bad;
   assign status.keep_zero = (keep_w == '0);
   assign status.pad_last  = (pad_left_ff == HOLD_CW'(1));
   assign status.rel_last  = ((HOLD_CW'(rel_idx_ff) + HOLD_CW'(1)) == keep_ff);

endmodule

### design/rkxc_ctrl.sv
// ----------------------------------------------------------------------------
// rkxc_ctrl
// Controller: accepts input beats and sequences held-byte swaps, pad checks,
// held-byte release and pad generation at message end.
// ----------------------------------------------------------------------------
module rkxc_ctrl
   import rkxc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_byte_present,
   input  logic          req_message_end,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      end_pend_ff, end_pend_in;
   logic      acc, pd;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign acc       = req_valid && req_ready;
   assign pd        = status.pad_en && status.dir;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         end_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         end_pend_ff <= end_pend_in;
      end
   end

   assign end_pend_in = acc ? req_message_end : end_pend_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_byte_present && pd && status.hold_full) begin
                  state_in = ST_SWAP;
               end else if (req_message_end && status.pad_en && !status.dir) begin
                  state_in = ST_PAD;
               end else if (req_message_end && pd) begin
                  state_in = ST_CHK_RD;
               end
            end
         end
         ST_SWAP: begin
            if (status.out_free) state_in = end_pend_ff ? ST_CHK_RD : ST_IDLE;
         end
         ST_CHK_RD: state_in = ST_CHK;
         ST_CHK: begin
            if (status.pad_bad || status.keep_zero) begin
               if (status.out_free) state_in = ST_IDLE;
            end else begin
               state_in = ST_REL;
            end
         end
         ST_REL: begin
            if (status.out_free && status.rel_last) state_in = ST_IDLE;
         end
         ST_PAD: begin
            if (status.out_free && status.pad_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd         = '0;
      cmd.xor_src = XS_INPUT;
      cmd.out_sel = OS_XOR;
      cmd.rd_sel  = RD_HEAD;
      unique case (state_ff)
         ST_IDLE: begin
            // read port sits on the head so a swap finds its byte ready
            if (acc) begin
               if (req_byte_present) begin
                  cmd.msg_adv = 1'b1;
                  cmd.key_adv = 1'b1;
                  if (pd) begin
                     if (status.hold_full) cmd.swap_latch = 1'b1;
                     else                  cmd.hold_append = 1'b1;
                  end else begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = req_message_end && !status.pad_en;
                  end
               end
               if (req_message_end) begin
                  if (!status.pad_en) begin
                     if (!req_byte_present) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OS_MARKER;
                        cmd.out_last = 1'b1;
                     end
                     cmd.finish = 1'b1;
                  end else if (!status.dir) begin
                     cmd.pad_latch = 1'b1;
                  end
               end
            end
         end
         ST_SWAP: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_sel    = OS_HELD;
               cmd.swap_write = 1'b1;
            end
         end
         ST_CHK_RD: cmd.rd_sel = RD_TAIL;
         ST_CHK: begin
            cmd.keep_latch = 1'b1;
            // on a bad pad or nothing kept, keep the pad byte on the read port while the
            // output is busy; otherwise move to the head for the first kept byte
            cmd.rd_sel = (status.pad_bad || status.keep_zero) ? RD_TAIL : RD_HEAD;
            if (status.pad_bad || status.keep_zero) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = status.pad_bad ? OS_ERROR : OS_MARKER;
                  cmd.out_last = 1'b1;
                  cmd.finish   = 1'b1;
               end
            end
         end
         ST_REL: begin
            cmd.rd_sel = RD_REL;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OS_HELD;
               cmd.out_last = status.rel_last;
               cmd.rel_adv  = 1'b1;
               cmd.finish   = status.rel_last;
            end
         end
         ST_PAD: begin
            cmd.xor_src = XS_PAD;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = status.pad_last;
               cmd.key_adv  = 1'b1;
               cmd.pad_dec  = 1'b1;
               cmd.finish   = status.pad_last;
            end
         end
         default: ;
      endcase
   end

endmodule

### design/repeating_key_xor_cipher_padded.sv
// ----------------------------------------------------------------------------
// repeating_key_xor_cipher_padded
// Repeating-key XOR stream cipher with 16-byte block padding and pad removal.
// ----------------------------------------------------------------------------
// Message bytes are XORed with a key of 1 to 32 bytes whose position restarts
// with every message. Mid-message one input beat is taken per cycle, except
// when decrypting with padding once 16 bytes are held: each further byte then
// also passes through the swap state, since the oldest held byte comes out of
// the hold RAM through its registered read port before it is sent. At the
// end of an encrypted padded message the 1 to 16 pad bytes follow at one per
// cycle. At the end of a decrypted padded message the pad byte is read, then
// checked, then the kept bytes leave at one per cycle. These rates hold while
// the result port does not stall. No input is taken while end-of-message
// results are being sent. The hold RAM needs no clearing after reset.
module repeating_key_xor_cipher_padded
   import rkxc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [WORD_W-1:0]   csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_present,
   input  logic                req_message_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_result_byte,
   output logic                rsp_result_present,
   output logic                rsp_result_last,
   output logic                rsp_pad_error
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rkxc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .status           (status),
      .cmd              (cmd)
   );

   rkxc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_data_byte      (req_data_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_byte    (rsp_result_byte),
      .rsp_result_present (rsp_result_present),
      .rsp_result_last    (rsp_result_last),
      .rsp_pad_error      (rsp_pad_error)
   );

endmodule

### design/rkxc_checker.sv
// ----------------------------------------------------------------------------
// rkxc_props
// Port-level checks for the cipher block, bound to the top level.
// ----------------------------------------------------------------------------
module rkxc_props
   import rkxc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                csr_we,
   input logic [CSR_IW-1:0]   csr_index,
   input logic [WORD_W-1:0]   csr_wdata,
   input logic                req_valid,
   input logic                req_ready,
   input logic [7:0]          req_data_byte,
   input logic                req_byte_present,
   input logic                req_message_end,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [7:0]          rsp_result_byte,
   input logic                rsp_result_present,
   input logic                rsp_result_last,
   input logic                rsp_pad_error
);

   // an error beat is a bare end marker
   a_err_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pad_error |-> !rsp_result_present && rsp_result_last)
      else $error("pad error beat carries a byte or is not last");

   // a marker beat carries a zero byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_present |-> rsp_result_byte == 8'd0)
      else $error("marker beat has nonzero byte");

   // no input is taken while a result is stalled
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_byte)
         && $stable(rsp_result_present) && $stable(rsp_result_last)
         && $stable(rsp_pad_error))
      else $error("stalled result changed");

endmodule

bind repeating_key_xor_cipher_padded rkxc_props u_rkxc_props (.*);

### verif/rkxc_checker.sv
// ----------------------------------------------------------------------------
// rkxc_checker
// Watches the request, result and register ports of the padded XOR cipher.
// For every request beat it predicts the result beats, then checks each
// result beat in order against them.
// ----------------------------------------------------------------------------
module rkxc_checker
   import rkxc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_present,
   input  logic              req_message_end,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_result_byte,
   input  logic              rsp_result_present,
   input  logic              rsp_result_last,
   input  logic              rsp_pad_error,
   output int                fail_count,
   output int                outstanding
);

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
      logic       err;
   } cipher_beat_type;

   cipher_beat_type expected_beats [$];

   // register copies
   logic [WORD_W-1:0]    key_word [KEY_WORDS];
   logic [KEY_LEN_W-1:0] key_length;
   logic                 padding_en;
   logic                 decrypt;

   // message state
   int         key_pos;
   int         block_pos;
   int         msg_len;
   int         hold_head;
   int         hold_count;
   logic [7:0] hold_buf [BLOCK_BYTES];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic int key_span();
      int len;
      len = int'(key_length);
      if (len == 0) len = 1;
      else if (len > KEY_BYTES) len = KEY_BYTES;
      return len;
   endfunction

   // XOR with the key byte at the current position, then advance it
   function automatic logic [7:0] next_keyed(logic [7:0] b);
      int                len;
      int                kp;
      logic [WORD_W-1:0] w;
      len = key_span();
      kp  = (key_pos < len) ? key_pos : 0;
      w   = key_word[kp / 8] >> (8 * (kp % 8));
      key_pos = (kp + 1 >= len) ? 0 : kp + 1;
      return b ^ w[7:0];
   endfunction

   function automatic void expect_beat(logic [7:0] d, logic p, logic l, logic e);
      cipher_beat_type b;
      b.data    = p ? d : 8'h00;
      b.present = p;
      b.last    = l;
      b.err     = e;
      expected_beats.insert(expected_beats.size(), b);
   endfunction

   function automatic void cipher_step(logic [7:0] d, logic p, logic e);
      logic [7:0] r;
      int         h;
      int         pn;
      int         pv;
      int         keep;
      logic       bad;
      if (p) begin
         r = next_keyed(d);
         if (msg_len < COUNT_SAT) msg_len++;
         block_pos = (block_pos + 1) % BLOCK_BYTES;
         if (padding_en && decrypt) begin
            if (hold_count >= BLOCK_BYTES) begin
               // oldest held byte leaves, newest takes its slot
               h = hold_head % BLOCK_BYTES;
               expect_beat(hold_buf[h], 1'b1, 1'b0, 1'b0);
               hold_buf[h] = r;
               hold_head   = (h + 1) % BLOCK_BYTES;
            end else begin
               hold_buf[(hold_head + hold_count) % BLOCK_BYTES] = r;
               hold_count++;
            end
         end else begin
            expect_beat(r, 1'b1, e && !padding_en, 1'b0);
         end
      end

      if (e) begin
         if (!padding_en) begin
            if (!p) expect_beat(8'h00, 1'b0, 1'b1, 1'b0);
         end else if (!decrypt) begin
            pn = BLOCK_BYTES - block_pos;
            for (int i = 0; i < pn; i++)
               expect_beat(next_keyed(8'(pn)), 1'b1, i + 1 == pn, 1'b0);
         end else begin
            bad = (hold_count == 0);
            if (!bad) begin
               pv = int'(hold_buf[(hold_head + hold_count - 1) % BLOCK_BYTES]);
               if (pv == 0 || pv > BLOCK_BYTES || pv > msg_len || pv > hold_count)
                  bad = 1'b1;
            end
            if (bad) begin
               expect_beat(8'h00, 1'b0, 1'b1, 1'b1);
            end else begin
               keep = hold_count - pv;
               if (keep == 0) expect_beat(8'h00, 1'b0, 1'b1, 1'b0);
               for (int i = 0; i < keep; i++)
                  expect_beat(hold_buf[(hold_head + i) % BLOCK_BYTES], 1'b1,
                              i + 1 == keep, 1'b0);
            end
         end
         key_pos    = 0;
         block_pos  = 0;
         msg_len    = 0;
         hold_head  = 0;
         hold_count = 0;
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      cipher_beat_type want;
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) key_word[i] = '0;
         key_length = KEY_LEN_W'(1);
         padding_en = 1'b1;
         decrypt    = 1'b0;
         key_pos    = 0;
         block_pos  = 0;
         msg_len    = 0;
         hold_head  = 0;
         hold_count = 0;
         expected_beats.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: byte 0x%0h present %0b last %0b err %0b",
                      rsp_result_byte, rsp_result_present, rsp_result_last, rsp_pad_error);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("result_byte", int'(want.data), int'(rsp_result_byte));
               check_field("result_present", int'(want.present), int'(rsp_result_present));
               check_field("result_last", int'(want.last), int'(rsp_result_last));
               check_field("pad_error", int'(want.err), int'(rsp_pad_error));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_WORD_0: key_word[0] = csr_wdata;
               CSR_KEY_WORD_1: key_word[1] = csr_wdata;
               CSR_KEY_WORD_2: key_word[2] = csr_wdata;
               CSR_KEY_WORD_3: key_word[3] = csr_wdata;
               CSR_KEY_LENGTH: key_length  = csr_wdata[KEY_LEN_W-1:0];
               CSR_PADDING_EN: padding_en  = csr_wdata[0];
               CSR_DIRECTION:  decrypt     = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            cipher_step(req_data_byte, req_byte_present, req_message_end);
      end
      outstanding = expected_beats.size();
   end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the padded repeating-key XOR cipher: a directed pass over the
// pad and key corner cases, then random messages under random key settings,
// mostly well-formed padded ciphertext when decrypting. Both sides idle at
// random; checking is done by rkxc_checker.
// ----------------------------------------------------------------------------
module tb
   import rkxc_pkg::*;
;

   localparam int STALL_LIMIT     = 1000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 400;
   localparam int QUIET_FROM      = 330;
   localparam int HOLD_OFF_CYCLES = 80;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_we           = 1'b0;
   logic [CSR_IW-1:0] csr_index        = '0;
   logic [WORD_W-1:0] csr_wdata        = '0;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [7:0]        req_data_byte    = 8'h00;
   logic              req_byte_present = 1'b0;
   logic              req_message_end  = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [7:0]        rsp_result_byte;
   logic              rsp_result_present;
   logic              rsp_result_last;
   logic              rsp_pad_error;

   int fail_count;
   int outstanding;
   int items_sent   = 0;
   int stall_cycles = 0;
   bit idle_on      = 1'b0;
   bit hold_off_req = 1'b0;

   // settings in force, used to build well-formed ciphertext
   logic [4*WORD_W-1:0] key_now  = '0;
   int                  klen_now = 1;
   bit                  pad_now  = 1'b1;
   bit                  dir_now  = 1'b0;

   always #6 clock = ~clock;

   repeating_key_xor_cipher_padded dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_message_end    (req_message_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_byte    (rsp_result_byte),
      .rsp_result_present (rsp_result_present),
      .rsp_result_last    (rsp_result_last),
      .rsp_pad_error      (rsp_pad_error)
   );

   rkxc_checker chk (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_message_end    (req_message_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_byte    (rsp_result_byte),
      .rsp_result_present (rsp_result_present),
      .rsp_result_last    (rsp_result_last),
      .rsp_pad_error      (rsp_pad_error),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // result side: random short stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic logic [7:0] key_stream(int pos);
      int                len;
      logic [WORD_W-1:0] w;
      len = klen_now;
      if (len == 0) len = 1;
      else if (len > KEY_BYTES) len = KEY_BYTES;
      pos = pos % len;
      w = key_now[(pos / 8) * WORD_W +: WORD_W] >> (8 * (pos % 8));
      return w[7:0];
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send(logic [7:0] d, logic p, logic e);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= d;
      req_byte_present <= p;
      req_message_end  <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (p || e) items_sent++;
   endtask

   // wait until every expected beat is in, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [WORD_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_mode(logic [4*WORD_W-1:0] key, int klen, bit pad, bit dir);
      drain();
      csr_write(CSR_KEY_WORD_0, key[0*WORD_W +: WORD_W]);
      csr_write(CSR_KEY_WORD_1, key[1*WORD_W +: WORD_W]);
      csr_write(CSR_KEY_WORD_2, key[2*WORD_W +: WORD_W]);
      csr_write(CSR_KEY_WORD_3, key[3*WORD_W +: WORD_W]);
      csr_write(CSR_KEY_LENGTH, WORD_W'(klen));
      csr_write(CSR_PADDING_EN, WORD_W'(pad));
      csr_write(CSR_DIRECTION, WORD_W'(dir));
      csr_we   <= 1'b0;
      key_now  = key;
      klen_now = klen;
      pad_now  = pad;
      dir_now  = dir;
   endtask

   task automatic send_plain(int len, bit joint);
      for (int i = 0; i < len; i++)
         send(8'($urandom_range(0, 255)), 1'b1, joint && i == len - 1);
      if (!joint || len == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // plaintext body plus pad_cnt bytes of pad_val, XORed with the key stream
   task automatic send_cipher(int body_len, int pad_val, int pad_cnt, bit joint);
      logic [7:0] plain [$];
      int         total;
      for (int i = 0; i < body_len; i++)
         plain.insert(plain.size(), 8'($urandom_range(0, 255)));
      for (int i = 0; i < pad_cnt; i++) plain.insert(plain.size(), 8'(pad_val));
      total = plain.size();
      for (int i = 0; i < total; i++)
         send(plain[i] ^ key_stream(i), 1'b1, joint && i == total - 1);
      if (!joint || total == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic random_message();
      int len;
      int pick;
      bit joint;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      joint = $urandom_range(0, 1);
      pick  = $urandom_range(0, 9);
      // stray beat with neither byte nor end
      if ($urandom_range(0, 9) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (pad_now && dir_now) begin
         if (pick < 7)
            send_cipher(len, BLOCK_BYTES - len % BLOCK_BYTES,
                        BLOCK_BYTES - len % BLOCK_BYTES, joint);
         else if (pick < 9)
            send_cipher(len, $urandom_range(0, 20), 1, joint);
         else
            send_plain(len, joint);
      end else begin
         send_plain(len, joint);
      end
   endtask

   task automatic random_config(int phase);
      int klen;
      bit pad;
      bit dir;
      case ($urandom_range(0, 5))
         0: klen = 1;
         1: klen = KEY_BYTES;
         2: klen = 0;
         3: klen = 63;
         default: klen = $urandom_range(1, KEY_BYTES);
      endcase
      pad = $urandom_range(0, 3) != 0;
      dir = $urandom_range(0, 2) != 0;
      if (phase == 0) begin
         klen = KEY_BYTES;
         pad  = 1'b1;
         dir  = 1'b1;
      end else if (phase == 2) begin
         klen = 1;
         pad  = 1'b1;
         dir  = 1'b0;
      end
      set_mode({random_word(), random_word(), random_word(), random_word()}, klen, pad, dir);
   endtask

   initial begin
      int random_start;
      int phase_end;
      int phase;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // encrypt with pad, key length 0 acting as 1
      set_mode('1, 0, 1'b1, 1'b0);
      send(8'h00, 1'b0, 1'b1);              // empty message: full block of pad
      send(8'h00, 1'b1, 1'b1);              // byte and end in one beat
      send(8'hff, 1'b1, 1'b0);
      send(8'h5c, 1'b0, 1'b1);
      send(8'ha7, 1'b0, 1'b0);              // no byte, no end

      // no padding, key length above range
      set_mode({random_word(), random_word(), random_word(), random_word()}, 63, 1'b0, 1'b0);
      send(8'hff, 1'b1, 1'b1);
      send(8'h3c, 1'b0, 1'b1);              // lone end marker
      send(8'h00, 1'b1, 1'b0);
      send(8'h81, 1'b1, 1'b1);
      send(8'h12, 1'b1, 1'b0);
      send(8'h34, 1'b1, 1'b0);
      send(8'h56, 1'b1, 1'b0);
      drain();
      csr_write(CSR_KEY_LENGTH, WORD_W'(2));  // shrink under the key position
      csr_we   <= 1'b0;
      klen_now = 2;
      send(8'h78, 1'b1, 1'b1);

      // decrypt with pad, zero key: bad pads, then good ones
      set_mode('0, 1, 1'b1, 1'b1);
      send(8'h00, 1'b0, 1'b1);              // empty message
      send(8'h00, 1'b1, 1'b1);              // pad of zero
      send(8'h11, 1'b1, 1'b1);              // pad above a block
      send(8'h5a, 1'b1, 1'b0);
      send(8'h03, 1'b1, 1'b1);              // pad longer than message
      send(8'haa, 1'b1, 1'b0);
      send(8'h01, 1'b1, 1'b1);
      send(8'h01, 1'b1, 1'b1);              // all pad: marker only

      // direction flipped with bytes held
      send(8'h9e, 1'b1, 1'b0);
      send(8'h61, 1'b1, 1'b0);
      set_mode('0, 1, 1'b1, 1'b0);
      send(8'h00, 1'b0, 1'b1);

      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         random_config(phase);
         idle_on   = (items_sent - random_start < QUIET_FROM) && $urandom_range(0, 3) != 0;
         phase_end = items_sent + $urandom_range(40, 60);
         if (phase == 1) begin
            // receiver holds off while a long message keeps coming
            hold_off_req = 1'b1;
            send_plain(40, 1'b1);
         end
         while (items_sent < phase_end) begin
            if (items_sent - random_start >= QUIET_FROM) idle_on = 1'b0;
            random_message();
            if ($urandom_range(0, 11) == 0) drain();
         end
         phase++;
      end

      idle_on = 1'b0;
      drain();
      if (fail_count == 0 && outstanding == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
